### rtl/mpg_pkg.sv
// Motion profile generator package: state encodings, handshake structs
// for the shared multiply-divide unit, and fixed arithmetic constants.
// No dependencies.
`default_nettype none

package mpg_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PROD,
        S_SQRT,
        S_TB,
        S_TV,
        S_NTB,
        S_NTV,
        S_CLAMP,
        S_T1,
        S_T2,
        S_T3,
        S_TT,
        S_ATB,
        S_M,
        S_P,
        S_CQ,
        S_CX,
        S_CX2,
        S_CTERM,
        S_CFIN,
        S_W,
        S_TERM,
        S_EMIT
    } ctl_state_t;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV,
        MD_DONE
    } md_state_t;

    typedef struct packed {
        logic        go;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
    } md_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
    } md_rsp_t;

    localparam logic       REQ_START   = 1'b0;
    localparam logic       MODE_SINOID = 1'b1;

    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_VMAX  = 2'd1;
    localparam logic [1:0] CFG_AMAX  = 2'd2;
    localparam logic [1:0] CFG_STEP  = 2'd3;

    localparam logic [63:0] US_PER_S      = 64'd1000000;
    localparam logic [63:0] TWO_US        = 64'd2000000;
    localparam logic [63:0] TWO_US2       = 64'd2000000000000;
    localparam logic [63:0] FOUR_US2      = 64'd4000000000000;
    localparam logic [63:0] EIGHT_PI2_US2 = 64'd78956835208715;
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam logic [63:0] COS_ONE       = 64'd131072;
    localparam logic [63:0] Q30_ONE       = 64'h0000_0000_4000_0000;
    localparam logic [63:0] TERM_CAP      = 64'h1000_0000_0000_0000;
    localparam logic [63:0] POS_MAX       = 64'd16777215;

    // Taylor divisor (2n-1)*2n in Q30
    function automatic logic [63:0] cos_div(input logic [3:0] n);
        logic [4:0] two_n;
        logic [9:0] prod;
        two_n = {n, 1'b0};
        prod  = 10'(two_n) * 10'(two_n - 5'd1);
        return 64'(prod) << 30;
    endfunction

endpackage

`default_nettype wire

### rtl/mpg_if.sv
// Handshake channels of the motion profile generator: request and response.
// No dependencies.
`default_nettype none

interface mpg_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [23:0] distance;
    modport source (output valid, output req_type, output distance, input ready);
    modport sink   (input valid, input req_type, input distance, output ready);
endinterface

interface mpg_rsp_if;
    logic        valid;
    logic        ready;
    logic [23:0] position;
    logic [19:0] step_index;
    logic [1:0]  phase;
    logic        last_sample;
    modport source (output valid, output position, output step_index, output phase,
                    output last_sample, input ready);
    modport sink   (input valid, input position, input step_index, input phase,
                    input last_sample, output ready);
endinterface

`default_nettype wire

### rtl/motion_profile_generator.sv
// Motion profile generator, top level. Depends on mpg_pkg, mpg_if, mpg_muldiv.
//
// A start transaction (req_type 0) plans a ramp or sinoid move over the given
// distance and gives no response; each tick transaction (req_type 1) while a
// move runs gives one response with the position of the next step. All
// products and quotients go through one bit-serial multiply-divide unit (64
// multiply steps, then 64 divide steps unless the result is capped). A start
// takes one product, a square root and seven unit operations; a tick takes 2
// to 4 operations for ramp and cruise and up to 22 for sinoid accel and decel,
// where the cosine is evaluated by a 12-term series. Registers are sampled
// when a transaction is accepted. COS_TABLE_DEPTH must be a power of two.
`default_nettype none

module motion_profile_generator
    import mpg_pkg::*;
#(
    parameter int MAX_STEPS       = 1048576,
    parameter int COS_TABLE_DEPTH = 1024
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mpg_req_if.sink    req,
    mpg_rsp_if.source  rsp,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int SW = $clog2(MAX_STEPS) + 1;
    localparam int TW = SW + 16;
    localparam int LD = $clog2(COS_TABLE_DEPTH);
    localparam logic [63:0] MAXS  = 64'(MAX_STEPS);
    localparam logic [63:0] DEPTH = 64'(COS_TABLE_DEPTH);

    ctl_state_t state_reg, state_next;

    logic        mode_reg;
    logic [21:0] vmax_reg;
    logic [23:0] amax_reg;
    logic [15:0] per_reg;

    logic        mode_q;
    logic [21:0] vmax_q;
    logic [23:0] acc_q;
    logic [15:0] per_q;
    logic [23:0] dist_q;

    logic          running_reg;
    logic [SW-1:0] step_reg, nacc_reg, ncru_reg, ndec_reg;
    logic [21:0]   peak_reg;
    logic [TW-1:0] tb_reg, tv_reg, te_reg;

    logic [63:0] sq_n_reg, sq_r_reg, sq_b_reg;
    logic [63:0] tbu_reg, tvu_reg, ntb_reg, ntv_reg;
    logic [63:0] t_reg, atb_reg, m_reg, w_reg, p_reg;
    logic signed [63:0] s_reg, csum_reg;
    logic [63:0] cterm_reg, x2_reg;
    logic [3:0]  cn_reg;
    logic [LD-1:0] k_reg;
    logic        cneg_reg;
    logic [18:0] oc_reg;
    logic [1:0]  term_reg;
    logic [1:0]  phase_reg;

    logic        ovalid_reg, last_reg;
    logic [23:0] pos_reg;
    logic [19:0] sidx_reg;
    logic [1:0]  oph_reg;

    md_req_t md_req;
    md_rsp_t md_rsp;

    mpg_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .md_req (md_req),
        .md_rsp (md_rsp)
    );

    logic        accept;
    logic [63:0] a64, v64, per64, tb64, tv64, te64;
    logic [63:0] dt, ttb, two_t;
    logic [63:0] sq_rb, sq_r_nxt, sq_n_nxt, v_clamp;
    logic        sq_hit;
    logic [63:0] ntb_c, ntv_c, nte_c, room1, room2;
    logic [SW+1:0] tot, idx1;
    logic [SW:0]   acc_cru;
    logic [1:0]  ph_c;
    logic        last_c, load_out;
    logic [1:0]  quad;
    logic [LD-1:0] rpart;
    logic [63:0] csum_pos, cround, cval;
    logic        term_neg, term_last;
    logic [23:0] pos_c;

    always_comb
    begin
        accept = req.valid && req.ready;
        a64    = 64'(acc_q);
        v64    = 64'(peak_reg);
        per64  = 64'(per_q);
        tb64   = 64'(tb_reg);
        tv64   = 64'(tv_reg);
        te64   = 64'(te_reg);
        dt     = (te64 > t_reg) ? te64 - t_reg : 64'd0;
        ttb    = (te64 > tb64) ? te64 - tb64 : 64'd0;
        two_t  = t_reg << 1;

        sq_rb    = sq_r_reg + sq_b_reg;
        sq_hit   = sq_n_reg >= sq_rb;
        sq_r_nxt = sq_hit ? (sq_r_reg >> 1) + sq_b_reg : sq_r_reg >> 1;
        sq_n_nxt = sq_hit ? sq_n_reg - sq_rb : sq_n_reg;
        v_clamp  = (sq_r_nxt > 64'(vmax_q)) ? 64'(vmax_q) : sq_r_nxt;

        ntb_c = (ntb_reg > MAXS) ? MAXS : ntb_reg;
        room1 = MAXS - ntb_c;
        ntv_c = (ntv_reg > room1) ? room1 : ntv_reg;
        room2 = room1 - ntv_c;
        nte_c = (ntb_reg > room2) ? room2 : ntb_reg;

        acc_cru = (SW+1)'(nacc_reg) + (SW+1)'(ncru_reg);
        tot     = (SW+2)'(acc_cru) + (SW+2)'(ndec_reg);
        idx1    = (SW+2)'(step_reg) + (SW+2)'(1);
        last_c  = idx1 >= tot;
        if (step_reg < nacc_reg)
            ph_c = PH_ACCEL;
        else if ((SW+1)'(step_reg) < acc_cru)
            ph_c = PH_CRUISE;
        else
            ph_c = PH_DECEL;

        quad  = p_reg[LD+1:LD];
        rpart = p_reg[LD-1:0];

        csum_pos = (csum_reg < 0) ? 64'd0 : 64'(csum_reg);
        cround   = (csum_pos + 64'd4096) >> 13;
        cval     = (cround > COS_ONE) ? COS_ONE : cround;

        if (s_reg < 0)
            pos_c = '0;
        else if (s_reg > $signed(POS_MAX))
            pos_c = 24'hFFFFFF;
        else
            pos_c = s_reg[23:0];

        load_out = (state_reg == S_EMIT) && (!ovalid_reg || rsp.ready);

        term_neg  = 1'b0;
        term_last = 1'b1;
        md_req    = '0;
        state_next = state_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_START)
                        state_next = S_PROD;
                    else if (running_reg)
                        state_next = S_TT;
                end
            end
            S_PROD:
            begin
                md_req = '{1'b1, 64'(dist_q), a64, 64'd1};
                if (md_rsp.done) state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sq_b_reg[0])
                    state_next = (v_clamp == 64'd0) ? S_IDLE : S_TB;
            end
            S_TB:
            begin
                md_req = '{1'b1, (mode_q == MODE_SINOID) ? v64 << 1 : v64, US_PER_S, a64};
                if (md_rsp.done) state_next = S_TV;
            end
            S_TV:
            begin
                md_req = '{1'b1, 64'(dist_q), US_PER_S, v64};
                if (md_rsp.done) state_next = S_NTB;
            end
            S_NTB:
            begin
                md_req = '{1'b1, tbu_reg, 64'd1, per64};
                if (md_rsp.done) state_next = S_NTV;
            end
            S_NTV:
            begin
                md_req = '{1'b1, (tvu_reg > tbu_reg) ? tvu_reg - tbu_reg : 64'd0,
                           64'd1, per64};
                if (md_rsp.done) state_next = S_CLAMP;
            end
            S_CLAMP: state_next = S_T1;
            S_T1:
            begin
                md_req = '{1'b1, 64'(nacc_reg), per64, 64'd1};
                if (md_rsp.done) state_next = S_T2;
            end
            S_T2:
            begin
                md_req = '{1'b1, 64'(acc_cru), per64, 64'd1};
                if (md_rsp.done) state_next = S_T3;
            end
            S_T3:
            begin
                md_req = '{1'b1, 64'(tot), per64, 64'd1};
                if (md_rsp.done) state_next = S_IDLE;
            end
            S_TT:
            begin
                md_req = '{1'b1, 64'(step_reg), per64, 64'd1};
                if (md_rsp.done)
                begin
                    if (ph_c == PH_CRUISE)
                        state_next = S_TERM;
                    else if (mode_q == MODE_SINOID)
                        state_next = S_ATB;
                    else
                        state_next = S_W;
                end
            end
            S_ATB:
            begin
                md_req = '{1'b1, a64, tb64, 64'd1};
                if (md_rsp.done) state_next = S_M;
            end
            S_M:
            begin
                md_req = '{1'b1, atb_reg, tb64, EIGHT_PI2_US2};
                if (md_rsp.done) state_next = S_P;
            end
            S_P:
            begin
                md_req = '{1'b1, (phase_reg == PH_ACCEL) ? t_reg :
                           ((t_reg > tv64) ? t_reg - tv64 : 64'd0),
                           DEPTH << 2, tb64};
                if (md_rsp.done) state_next = S_CQ;
            end
            S_CQ:
            begin
                if (quad[0] && rpart == '0)
                    state_next = S_W;
                else
                    state_next = S_CX;
            end
            S_CX:
            begin
                md_req = '{1'b1, 64'(k_reg), HALF_PI_Q30, DEPTH};
                if (md_rsp.done) state_next = S_CX2;
            end
            S_CX2:
            begin
                md_req = '{1'b1, cterm_reg, cterm_reg, Q30_ONE};
                if (md_rsp.done) state_next = S_CTERM;
            end
            S_CTERM:
            begin
                md_req = '{1'b1, cterm_reg, x2_reg, cos_div(cn_reg)};
                if (md_rsp.done && cn_reg == 4'd12) state_next = S_CFIN;
            end
            S_CFIN: state_next = S_W;
            S_W:
            begin
                md_req = '{1'b1, a64, (phase_reg == PH_DECEL) ? dt : t_reg, 64'd1};
                if (md_rsp.done) state_next = S_TERM;
            end
            S_TERM:
            begin
                md_req.go = 1'b1;
                case ({mode_q, phase_reg})
                    {1'b0, PH_ACCEL}:
                    begin
                        md_req.x = w_reg; md_req.y = t_reg; md_req.z = TWO_US2;
                    end
                    {1'b0, PH_CRUISE}:
                    begin
                        term_last = term_reg == 2'd1;
                        term_neg  = term_reg == 2'd1;
                        md_req.x  = v64;
                        md_req.y  = (term_reg == 2'd1) ? v64 : t_reg;
                        md_req.z  = (term_reg == 2'd1) ? a64 << 1 : US_PER_S;
                    end
                    {1'b0, PH_DECEL}:
                    begin
                        term_last = term_reg == 2'd1;
                        term_neg  = term_reg == 2'd1;
                        md_req.x  = (term_reg == 2'd1) ? w_reg : v64;
                        md_req.y  = (term_reg == 2'd1) ? dt : ttb;
                        md_req.z  = (term_reg == 2'd1) ? TWO_US2 : US_PER_S;
                    end
                    {1'b1, PH_ACCEL}:
                    begin
                        term_last = term_reg == 2'd1;
                        term_neg  = term_reg == 2'd1;
                        md_req.x  = (term_reg == 2'd1) ? m_reg : w_reg;
                        md_req.y  = (term_reg == 2'd1) ? 64'(oc_reg) : t_reg;
                        md_req.z  = (term_reg == 2'd1) ? COS_ONE : FOUR_US2;
                    end
                    {1'b1, PH_CRUISE}:
                    begin
                        md_req.x = v64;
                        md_req.y = (two_t >= tb64) ? two_t - tb64 : 64'd0;
                        md_req.z = TWO_US;
                    end
                    default:
                    begin
                        term_last = term_reg == 2'd2;
                        term_neg  = term_reg == 2'd1;
                        case (term_reg)
                            2'd0:
                            begin
                                md_req.x = atb_reg; md_req.y = ttb; md_req.z = TWO_US2;
                            end
                            2'd1:
                            begin
                                md_req.x = w_reg; md_req.y = dt; md_req.z = FOUR_US2;
                            end
                            default:
                            begin
                                md_req.x = m_reg; md_req.y = 64'(oc_reg); md_req.z = COS_ONE;
                            end
                        endcase
                    end
                endcase
                if (md_rsp.done && term_last) state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (load_out) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = ovalid_reg;
    assign rsp.position    = pos_reg;
    assign rsp.step_index  = sidx_reg;
    assign rsp.phase       = oph_reg;
    assign rsp.last_sample = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= 1'b0;
            vmax_reg    <= 22'd1048576;
            amax_reg    <= 24'd1048576;
            per_reg     <= 16'd1000;
            running_reg <= 1'b0;
            step_reg    <= '0;
            nacc_reg    <= '0;
            ncru_reg    <= '0;
            ndec_reg    <= '0;
            peak_reg    <= '0;
            tb_reg      <= '0;
            tv_reg      <= '0;
            te_reg      <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE: mode_reg <= cfg_data[0];
                    CFG_VMAX: vmax_reg <= cfg_data[21:0];
                    CFG_AMAX: amax_reg <= cfg_data;
                    CFG_STEP: per_reg  <= cfg_data[15:0];
                    default:  mode_reg <= mode_reg;
                endcase
            end

            if (accept && req.req_type == REQ_START)
            begin
                running_reg <= 1'b0;
                step_reg    <= '0;
                nacc_reg    <= '0;
                ncru_reg    <= '0;
                ndec_reg    <= '0;
                peak_reg    <= '0;
                tb_reg      <= '0;
                tv_reg      <= '0;
                te_reg      <= '0;
            end

            if (state_reg == S_SQRT && sq_b_reg[0])
                peak_reg <= v_clamp[21:0];
            if (state_reg == S_CLAMP)
            begin
                nacc_reg <= SW'(ntb_c);
                ncru_reg <= SW'(ntv_c);
                ndec_reg <= SW'(nte_c);
            end
            if (md_rsp.done)
            begin
                case (state_reg)
                    S_T1: tb_reg <= TW'(md_rsp.q);
                    S_T2: tv_reg <= TW'(md_rsp.q);
                    S_T3:
                    begin
                        te_reg      <= TW'(md_rsp.q);
                        running_reg <= tot != '0;
                    end
                    default: te_reg <= te_reg;
                endcase
            end

            if (load_out)
            begin
                step_reg <= SW'(idx1);
                if (last_c) running_reg <= 1'b0;
            end

            if (load_out)
                ovalid_reg <= 1'b1;
            else if (rsp.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_q <= mode_reg;
            vmax_q <= vmax_reg;
            acc_q  <= amax_reg;
            per_q  <= (per_reg == 16'd0) ? 16'd1 : per_reg;
            dist_q <= req.distance;
        end
        if (load_out)
        begin
            pos_reg  <= pos_c;
            sidx_reg <= 20'(step_reg);
            oph_reg  <= phase_reg;
            last_reg <= last_c;
        end
        case (state_reg)
            S_PROD:
            begin
                sq_n_reg <= (mode_q == MODE_SINOID) ? md_rsp.q >> 1 : md_rsp.q;
                sq_r_reg <= '0;
                sq_b_reg <= 64'd1 << 62;
            end
            S_SQRT:
            begin
                sq_n_reg <= sq_n_nxt;
                sq_r_reg <= sq_r_nxt;
                sq_b_reg <= sq_b_reg >> 2;
            end
            S_TB:  if (md_rsp.done) tbu_reg <= md_rsp.q;
            S_TV:  if (md_rsp.done) tvu_reg <= md_rsp.q;
            S_NTB: if (md_rsp.done) ntb_reg <= md_rsp.q;
            S_NTV: if (md_rsp.done) ntv_reg <= md_rsp.q;
            S_TT:
            begin
                t_reg     <= md_rsp.q;
                phase_reg <= ph_c;
                term_reg  <= '0;
                s_reg     <= '0;
                oc_reg    <= 19'(COS_ONE);
            end
            S_ATB: atb_reg <= md_rsp.q;
            S_M:   m_reg   <= md_rsp.q;
            S_P:   p_reg   <= md_rsp.q;
            S_CQ:
            begin
                k_reg    <= quad[0] ? {LD{1'b0}} - rpart : rpart;
                cneg_reg <= (quad == 2'd1) || (quad == 2'd2);
            end
            S_CX:  cterm_reg <= md_rsp.q;
            S_CX2:
            begin
                x2_reg    <= md_rsp.q;
                cterm_reg <= Q30_ONE;
                csum_reg  <= $signed(Q30_ONE);
                cn_reg    <= 4'd1;
            end
            S_CTERM:
            begin
                if (md_rsp.done)
                begin
                    cterm_reg <= md_rsp.q;
                    csum_reg  <= cn_reg[0] ? csum_reg - $signed(md_rsp.q)
                                           : csum_reg + $signed(md_rsp.q);
                    cn_reg    <= cn_reg + 4'd1;
                end
            end
            S_CFIN:
                oc_reg <= cneg_reg ? 19'(COS_ONE + cval) : 19'(COS_ONE - cval);
            S_W:   w_reg <= md_rsp.q;
            S_TERM:
            begin
                if (md_rsp.done)
                begin
                    s_reg    <= term_neg ? s_reg - $signed(md_rsp.q)
                                         : s_reg + $signed(md_rsp.q);
                    term_reg <= term_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/mpg_muldiv.sv
// Bit-serial floor(x*y/z) unit, 64-bit operands, 128-bit product, result
// capped at 2^60 (also on overflow or zero divisor). Depends on mpg_pkg.
`default_nettype none

module mpg_muldiv
    import mpg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  md_req_t   md_req,
    output md_rsp_t   md_rsp
);

    md_state_t    st_reg, st_next;
    logic [63:0]  x_reg, y_reg, z_reg, q_reg;
    logic [127:0] p_reg;
    logic [5:0]   cnt_reg;

    logic [64:0]  sum;
    logic [63:0]  rem2, rem_new;
    logic         sub, cap;

    always_comb
    begin
        sum     = {1'b0, p_reg[127:64]} + (y_reg[0] ? {1'b0, x_reg} : 65'd0);
        rem2    = {p_reg[126:64], p_reg[63]};
        sub     = p_reg[127] || (rem2 >= z_reg);
        rem_new = sub ? rem2 - z_reg : rem2;
        cap     = (z_reg == 64'd0) || (p_reg[127:64] >= z_reg);
        md_rsp.done = (st_reg == MD_DONE);
        md_rsp.q    = (q_reg > TERM_CAP) ? TERM_CAP : q_reg;
        st_next = st_reg;
        case (st_reg)
            MD_IDLE: if (md_req.go) st_next = MD_MUL;
            MD_MUL:  if (cnt_reg == 6'd63) st_next = MD_CHK;
            MD_CHK:  st_next = cap ? MD_DONE : MD_DIV;
            MD_DIV:  if (cnt_reg == 6'd63) st_next = MD_DONE;
            MD_DONE: st_next = MD_IDLE;
            default: st_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= MD_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            MD_IDLE:
            begin
                x_reg   <= md_req.x;
                y_reg   <= md_req.y;
                z_reg   <= md_req.z;
                p_reg   <= '0;
                cnt_reg <= '0;
            end
            MD_MUL:
            begin
                p_reg   <= {sum, p_reg[63:1]};
                y_reg   <= y_reg >> 1;
                cnt_reg <= cnt_reg + 6'd1;
            end
            MD_CHK:
            begin
                q_reg   <= cap ? TERM_CAP : 64'd0;
                cnt_reg <= '0;
            end
            MD_DIV:
            begin
                p_reg   <= {rem_new, p_reg[62:0], 1'b0};
                q_reg   <= {q_reg[62:0], sub};
                cnt_reg <= cnt_reg + 6'd1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for motion_profile_generator: ramp and sinoid moves,
// with positions predicted in the bench and compared per response transaction.
// Depends on mpg_pkg, mpg_if and the RTL of the block.
`default_nettype none

module tb_top
    import mpg_pkg::*;
();

    localparam int          COS_DEPTH = 1024;
    localparam logic [63:0] STEP_CAP  = 64'd1048576;
    localparam int          SETTLE    = 3500;
    localparam longint      LIMIT     = 64'd60000000;

    typedef struct packed {
        logic [23:0] position;
        logic [19:0] step_index;
        logic [1:0]  phase;
        logic        last_sample;
    } sample_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    mpg_req_if req_ch ();
    mpg_rsp_if rsp_ch ();

    motion_profile_generator uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic        mode_m;
    logic [21:0] vmax_m;
    logic [23:0] amax_m;
    logic [15:0] per_m;
    bit          moving;
    logic [63:0] step_ctr, n_acc, n_cru, n_dec, v_peak, t_acc_end, t_cru_end, t_total;
    logic [17:0] cos_rom [COS_DEPTH];

    sample_t pending_samples [$];
    int      errors;
    int      snd_idle_pct;
    int      rcv_idle_pct;
    bit      hold_rsp;
    longint  cycles = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] mul_div(input logic [63:0] x, input logic [63:0] y,
                                            input logic [63:0] z);
        logic [127:0] q;
        if (z == 64'd0)
            return TERM_CAP;
        q = ({64'd0, x} * {64'd0, y}) / {64'd0, z};
        return (q > {64'd0, TERM_CAP}) ? TERM_CAP : q[63:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 64'd0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [17:0] cos_q17(input int k);
        logic [63:0] x, x2, term, v, dv;
        longint      s;
        x    = mul_div(64'(k), HALF_PI_Q30, 64'(COS_DEPTH));
        x2   = (x * x) >> 30;
        term = Q30_ONE;
        s    = $signed(term);
        for (int n = 1; n <= 12; n++)
        begin
            dv   = 64'((2 * n - 1) * (2 * n)) << 30;
            term = mul_div(term, x2, dv);
            if (n % 2 == 1)
                s = s - $signed(term);
            else
                s = s + $signed(term);
        end
        if (s < 0)
            s = 0;
        v = (64'(s) + 64'd4096) >> 13;
        return (v > COS_ONE) ? COS_ONE[17:0] : v[17:0];
    endfunction

    // cosine of p/(4*depth) of a full turn, signed Q17
    function automatic longint cos_turn(input logic [63:0] p);
        logic [63:0] q, r, c;
        p = p % (4 * COS_DEPTH);
        q = p / COS_DEPTH;
        r = p % COS_DEPTH;
        if (q[0])
            c = (r == 64'd0) ? 64'd0 : 64'(cos_rom[COS_DEPTH - r]);
        else
            c = 64'(cos_rom[r]);
        return (q == 64'd1 || q == 64'd2) ? -$signed(c) : $signed(c);
    endfunction

    function automatic longint path_position(input logic [63:0] i, output logic [1:0] ph);
        logic [63:0] a, v, per, t, tb, tv, te, dt, ttb, m, oc;
        longint      s;
        a   = 64'(amax_m);
        v   = v_peak;
        per = (per_m != 16'd0) ? 64'(per_m) : 64'd1;
        t   = i * per;
        tb  = t_acc_end;
        tv  = t_cru_end;
        te  = t_total;
        dt  = (te > t) ? te - t : 64'd0;
        ttb = (te > tb) ? te - tb : 64'd0;
        m   = mul_div(a * tb, tb, EIGHT_PI2_US2);
        if (i < n_acc)
        begin
            ph = PH_ACCEL;
            if (mode_m != MODE_SINOID)
                return $signed(mul_div(a * t, t, TWO_US2));
            oc = 64'($signed(COS_ONE) - cos_turn(mul_div(t, 64'(4 * COS_DEPTH), tb)));
            return $signed(mul_div(a * t, t, FOUR_US2)) - $signed(mul_div(m, oc, COS_ONE));
        end
        if (i < n_acc + n_cru)
        begin
            ph = PH_CRUISE;
            if (mode_m != MODE_SINOID)
                return $signed(mul_div(v, t, US_PER_S)) - $signed(mul_div(v, v, 2 * a));
            return (2 * t >= tb) ? $signed(mul_div(v, 2 * t - tb, TWO_US)) : 0;
        end
        ph = PH_DECEL;
        if (mode_m != MODE_SINOID)
            return $signed(mul_div(v, ttb, US_PER_S)) - $signed(mul_div(a * dt, dt, TWO_US2));
        oc = 64'($signed(COS_ONE)
                 - cos_turn(mul_div((t > tv) ? t - tv : 64'd0, 64'(4 * COS_DEPTH), tb)));
        s  = $signed(mul_div(a * tb, ttb, TWO_US2)) - $signed(mul_div(a * dt, dt, FOUR_US2));
        return s + $signed(mul_div(m, oc, COS_ONE));
    endfunction

    task automatic plan_move(input logic [23:0] path_len);
        logic [63:0] a, per, prod, v, tb, tv, ntb, ntv, nte, room;
        a    = 64'(amax_m);
        per  = (per_m != 16'd0) ? 64'(per_m) : 64'd1;
        prod = 64'(path_len) * a;
        if (mode_m == MODE_SINOID)
            prod = prod >> 1;
        v = root64(prod);
        if (v > 64'(vmax_m))
            v = 64'(vmax_m);
        moving    = 1'b0;
        step_ctr  = 64'd0;
        n_acc     = 64'd0;
        n_cru     = 64'd0;
        n_dec     = 64'd0;
        v_peak    = v;
        t_acc_end = 64'd0;
        t_cru_end = 64'd0;
        t_total   = 64'd0;
        if (v == 64'd0)
            return;
        tb  = ((mode_m == MODE_SINOID) ? 2 * v : v) * US_PER_S / a;
        tv  = 64'(path_len) * US_PER_S / v;
        ntb = tb / per;
        ntv = ((tv > tb) ? tv - tb : 64'd0) / per;
        nte = ntb;
        if (ntb > STEP_CAP)
            ntb = STEP_CAP;
        room = STEP_CAP - ntb;
        if (ntv > room)
            ntv = room;
        room = room - ntv;
        if (nte > room)
            nte = room;
        n_acc     = ntb;
        n_cru     = ntv;
        n_dec     = nte;
        t_acc_end = ntb * per;
        t_cru_end = (ntb + ntv) * per;
        t_total   = (ntb + ntv + nte) * per;
        moving    = (ntb + ntv + nte) != 64'd0;
    endtask

    task automatic next_sample();
        logic [63:0] i, total;
        logic [1:0]  ph;
        longint      s;
        sample_t     smp;
        if (!moving)
            return;
        i     = step_ctr;
        total = n_acc + n_cru + n_dec;
        s     = path_position(i, ph);
        if (s < 0)
            s = 0;
        if (s > $signed(POS_MAX))
            s = $signed(POS_MAX);
        smp.position    = s[23:0];
        smp.step_index  = i[19:0];
        smp.phase       = ph;
        smp.last_sample = (i + 1 >= total);
        pending_samples = {pending_samples, smp};
        step_ctr = i + 1;
        if (i + 1 >= total)
            moving = 1'b0;
    endtask

    // one request transaction; valid stays high afterwards until the next send or drain
    task automatic send(input logic rtype, input logic [23:0] path_len);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rtype;
        req_ch.distance <= path_len;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (rtype == REQ_START)
            plan_move(path_len);
        else
            next_sample();
    endtask

    task automatic run_ticks(input int n);
        for (int k = 0; k < n; k++)
            send(~REQ_START, 24'($urandom()));
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic mode, input logic [21:0] vmax,
                             input logic [23:0] amax, input logic [15:0] per);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data  <= 24'(mode);
        @(posedge clk);
        cfg_index <= CFG_VMAX;
        cfg_data  <= 24'(vmax);
        @(posedge clk);
        cfg_index <= CFG_AMAX;
        cfg_data  <= amax;
        @(posedge clk);
        cfg_index <= CFG_STEP;
        cfg_data  <= 24'(per);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        mode_m = mode;
        vmax_m = vmax;
        amax_m = amax;
        per_m  = per;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || hold_rsp)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        sample_t got, want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = {rsp_ch.position, rsp_ch.step_index, rsp_ch.phase, rsp_ch.last_sample};
            if (pending_samples.size() == 0)
            begin
                $display("%0t: transaction exp none got %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (got.position !== want.position)
                begin
                    $display("%0t: position exp %0d got %0d", $time, want.position,
                             got.position);
                    errors++;
                end
                if (got.step_index !== want.step_index)
                begin
                    $display("%0t: step_index exp %0d got %0d", $time, want.step_index,
                             got.step_index);
                    errors++;
                end
                if (got.phase !== want.phase)
                begin
                    $display("%0t: phase exp %0d got %0d", $time, want.phase, got.phase);
                    errors++;
                end
                if (got.last_sample !== want.last_sample)
                begin
                    $display("%0t: last_sample exp %0d got %0d", $time, want.last_sample,
                             got.last_sample);
                    errors++;
                end
            end
        end
    end

    task automatic test_defaults();
        run_ticks(2);
        send(REQ_START, 24'd16);
        run_ticks(7);
    endtask

    task automatic test_extremes();
        write_cfg(1'b0, 22'h3FFFFF, 24'hFFFFFF, 16'hFFFF);
        send(REQ_START, 24'd2000000);
        run_ticks(int'(n_acc + n_cru + n_dec));
        write_cfg(MODE_SINOID, 22'h3FFFFF, 24'hFFFFFF, 16'hFFFF);
        send(REQ_START, 24'd2000000);
        run_ticks(int'(n_acc + n_cru + n_dec));
        send(REQ_START, 24'd0);
        run_ticks(1);
        send(REQ_START, 24'd1);
        run_ticks(1);
    endtask

    task automatic test_step_limit();
        write_cfg(1'b0, 22'h3FFFFF, 24'd1, 16'd1);
        send(REQ_START, 24'hFFFFFF);
        run_ticks(3);
        write_cfg(MODE_SINOID, 22'h3FFFFF, 24'd1, 16'd1);
        send(REQ_START, 24'hFFFFFF);
        run_ticks(3);
    endtask

    task automatic test_zero_period();
        write_cfg(MODE_SINOID, 22'h3FFFFF, 24'hFFFFFF, 16'd0);
        send(REQ_START, 24'd1);
        run_ticks(4);
        send(REQ_START, 24'd1);
        run_ticks(3);
    endtask

    task automatic test_backpressure();
        write_cfg(1'b0, 22'd1048576, 24'd1048576, 16'd50000);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        fork
            begin
                hold_rsp = 1'b1;
                repeat (20000) @(posedge clk);
                hold_rsp = 1'b0;
            end
        join_none
        send(REQ_START, 24'd1048576);
        run_ticks(int'(n_acc + n_cru + n_dec));
    endtask

    task automatic random_cfg();
        logic [21:0] vmax;
        logic [23:0] amax;
        logic [15:0] per;
        vmax = 22'($urandom_range(1, 22'h3FFFFF) >> $urandom_range(0, 12));
        amax = 24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 14));
        per  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                           : 16'($urandom_range(20000, 16'hFFFF));
        if (vmax == 22'd0)
            vmax = 22'd1;
        if (amax == 24'd0)
            amax = 24'd1;
        write_cfg(1'($urandom_range(0, 1)), vmax, amax, per);
    endtask

    task automatic test_random(input int n_items);
        int          sent;
        int          total;
        int          ticks;
        logic [23:0] path_len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 2) == 0)
                random_cfg();
            if ($urandom_range(0, 99) < 85)
            begin
                path_len = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16));
                send(REQ_START, path_len);
                total = int'(n_acc + n_cru + n_dec);
                if (total <= 60)
                    ticks = total + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
                else
                    ticks = $urandom_range(1, 40);
                run_ticks(ticks);
                sent = sent + 1 + ((ticks < total) ? ticks : total);
            end
            else
            begin
                send(1'($urandom_range(0, 1)), 24'($urandom()));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_MODE;
        cfg_data        = 24'd0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_START;
        req_ch.distance = 24'd0;
        rsp_ch.ready    = 1'b0;
        hold_rsp        = 1'b0;
        errors          = 0;
        snd_idle_pct    = 35;
        rcv_idle_pct    = 74;
        mode_m          = 1'b0;
        vmax_m          = 22'd1048576;
        amax_m          = 24'd1048576;
        per_m           = 16'd1000;
        moving          = 1'b0;
        step_ctr        = 64'd0;
        n_acc           = 64'd0;
        n_cru           = 64'd0;
        n_dec           = 64'd0;
        v_peak          = 64'd0;
        t_acc_end       = 64'd0;
        t_cru_end       = 64'd0;
        t_total         = 64'd0;
        for (int k = 0; k < COS_DEPTH; k++)
            cos_rom[k] = cos_q17(k);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_extremes();
        test_step_limit();
        test_zero_period();
        test_random(660);
        snd_idle_pct = 74;
        rcv_idle_pct = 35;
        test_random(660);
        test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random(660);

        drain();
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### motion_profile_generator.f
rtl/mpg_pkg.sv
rtl/mpg_if.sv
rtl/mpg_muldiv.sv
rtl/motion_profile_generator.sv
test/tb_top.sv
